// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/aes256_pkg.sv -----
// Package for the AES-256 block cipher: command types, S-box tables, GF(2^8) helpers.
// Used by aes256_ctrl, aes256_dp and aes256_block_cipher.
`default_nettype none
package aes256_pkg;

  localparam int Rounds   = 14;
  localparam int Words    = 60;
  localparam int KeyWords = 8;
  localparam int RndW     = 4;
  localparam int WIdxW    = 6;

  localparam logic [1:0] CFG_KEY0 = 2'd0;
  localparam logic [1:0] CFG_KEY1 = 2'd1;
  localparam logic [1:0] CFG_KEY2 = 2'd2;
  localparam logic [1:0] CFG_KEY3 = 2'd3;
  localparam int CfgIdxW = 2;

  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  typedef struct packed {
    logic         load;      // capture input block (the first round key is added afterwards)
    logic         round;     // run one round
    logic         last;      // the round is the final one (no mix)
    logic [RndW-1:0] rnd;    // round number for the key read
    logic         kx_start;  // start key expansion
    logic         kx_step;   // compute one expanded word
    logic         dec;       // direction of the block in flight
  } dp_cmd_t;

  typedef struct packed {
    logic kx_done;
  } dp_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/aes256_block_cipher.sv -----
// AES-256 block cipher top level: key registers, controller and datapath.
// Depends on aes256_pkg, aes256_ctrl and aes256_dp.
// Each block passes the first key add, 14 rounds and the result offer; the first block
//   accepted after reset or a key write first runs key expansion.
// A new block is accepted only after the previous result is taken; there is a single round unit.
// Reset: synchronous active-low rst_n clears keys to zero and marks round keys stale.
`default_nettype none
module aes256_block_cipher
  import aes256_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [127:0]       in_tdata,   // block_hi [63:0], block_lo [127:64]
  input  wire logic               in_tuser,   // cmd
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [127:0]            out_tdata,  // result_hi [63:0], result_lo [127:64]
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [63:0]        cfg_wdata
);

  logic [63:0] key0_r, key1_r, key2_r, key3_r;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [127:0] result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY0: key0_r <= cfg_wdata;
        CFG_KEY1: key1_r <= cfg_wdata;
        CFG_KEY2: key2_r <= cfg_wdata;
        CFG_KEY3: key3_r <= cfg_wdata;
        default:  key0_r <= key0_r;
      endcase
    end
  end

  aes256_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .key_write  (cfg_we),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  aes256_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .key0   (key0_r),
    .key1   (key1_r),
    .key2   (key2_r),
    .key3   (key3_r),
    .blk_hi (in_tdata[63:0]),
    .blk_lo (in_tdata[127:64]),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

  assign out_tdata = {result[63:0], result[127:64]};

endmodule
`default_nettype wire

// ----- rtl/aes256_ctrl.sv -----
// Sequencer for the AES-256 cipher: handshake, key expansion and round count.
// Depends on aes256_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module aes256_ctrl
  import aes256_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire logic    in_cmd,
  input  wire logic    key_write,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KX   = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [RndW-1:0] cnt_r, cnt_nxt;
  logic            keys_ok_r, keys_ok_nxt;
  logic            dec_r, dec_nxt;
  logic            in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    keys_ok_nxt = keys_ok_r;
    dec_nxt     = dec_r;
    cmd         = '0;
    cmd.dec     = dec_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dec_nxt = in_cmd;
          cmd.dec = in_cmd;
          cmd.load = 1'b1;
          // latch the block now; expansion runs before the first key read
          if (keys_ok_r) begin
            cmd.rnd   = (in_cmd == CMD_DEC) ? RndW'(Rounds) : '0;
            state_nxt = ST_LOAD;
          end else begin
            cmd.kx_start = 1'b1;
            state_nxt    = ST_KX;
          end
        end
      end
      ST_KX: begin
        cmd.kx_step = 1'b1;
        if (sts.kx_done) begin
          keys_ok_nxt = 1'b1;
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // apply the first round key to the stored block
        cmd.rnd   = dec_r ? RndW'(Rounds) : '0;
        cmd.round = 1'b0;
        cnt_nxt   = RndW'(1);
        state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.round = 1'b1;
        cmd.last  = (cnt_r == RndW'(Rounds));
        cmd.rnd   = dec_r ? RndW'(Rounds) - cnt_r : cnt_r;
        cnt_nxt   = cnt_r + RndW'(1);
        if (cnt_r == RndW'(Rounds)) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (key_write) keys_ok_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      keys_ok_r <= 1'b0;
      dec_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      keys_ok_r <= keys_ok_nxt;
      dec_r     <= dec_nxt;
    end
  end

  `ASSERT_NEXT(a_kx_needs_stale, in_acc && !keys_ok_r, state_r == ST_KX, "keys not expanded")
  `ASSERT_IMPL(a_cnt_range, state_r == ST_RND, cnt_r != '0 && cnt_r <= RndW'(Rounds), "bad round")
  `ASSERT_NEXT(a_done_out, state_r == ST_RND && cnt_r == RndW'(Rounds), out_tvalid, "no result")

endmodule
`default_nettype wire

// ----- rtl/aes256_dp.sv -----
// Datapath for the AES-256 cipher: state register, one round unit, key schedule memory.
// Depends on aes256_pkg.
`default_nettype none
module aes256_dp
  import aes256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [63:0] key0,
  input  wire logic [63:0] key1,
  input  wire logic [63:0] key2,
  input  wire logic [63:0] key3,
  input  wire logic [63:0] blk_hi,
  input  wire logic [63:0] blk_lo,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  output logic [127:0]     result
);

  // round keys stored as 15 rows of 128 bits, read by round number
  logic [127:0] rk_mem [Rounds+1];
  logic [127:0] st_r, st_nxt;
  logic [255:0] win_r, win_nxt;     // last eight schedule words, word 0 in top bits
  logic [WIdxW-1:0] wi_r, wi_nxt;   // index of next word to compute
  logic [7:0]   rc_r, rc_nxt;
  logic [127:0] row_buf_r, row_buf_nxt;
  logic         kx_busy_r, kx_busy_nxt;
  logic [31:0]  t, nw;
  logic [127:0] rk;
  logic [7:0]   s [16];
  logic [7:0]   a [16];
  logic [7:0]   m [16];
  logic [127:0] sr_out, mix_out;
  logic [RndW-1:0] wr_row;
  logic         wr_en;
  logic [127:0] wr_data;
  logic [127:0] dec_in;
  logic [127:0] enc_mixed, dec_sr_in;
  logic [7:0]   d [16];
  logic [127:0] dec_round;
  logic         first_add;
  logic [127:0] x14, first_dec;
  logic         load_pend_r;

  assign rk     = rk_mem[cmd.rnd];
  assign result = st_r;

  // key schedule: one word per cycle while cmd.kx_step is set, window of the last eight words
  always_comb begin
    t = win_r[31:0];
    if (wi_r[2:0] == 3'd0) t = sub_word({t[23:0], t[31:24]}) ^ {rc_r, 24'h0};
    else if (wi_r[2:0] == 3'd4) t = sub_word(t);
    nw = win_r[255:224] ^ t;
  end

  always_comb begin
    win_nxt     = win_r;
    wi_nxt      = wi_r;
    rc_nxt      = rc_r;
    row_buf_nxt = row_buf_r;
    kx_busy_nxt = kx_busy_r;
    wr_en       = 1'b0;
    wr_row      = '0;
    wr_data     = row_buf_nxt;
    sts.kx_done = 1'b0;
    if (cmd.kx_start) begin
      win_nxt     = {key0, key1, key2, key3};
      wi_nxt      = WIdxW'(KeyWords);
      rc_nxt      = 8'h01;
      kx_busy_nxt = 1'b1;
      wr_en       = 1'b1;
      wr_row      = '0;
      wr_data     = {key0, key1};
    end else if (cmd.kx_step && kx_busy_r) begin
      if (wi_r == WIdxW'(KeyWords)) begin
        // row 1 comes from the raw key
        wr_en   = 1'b1;
        wr_row  = RndW'(1);
        wr_data = win_r[127:0];
      end
      win_nxt     = {win_r[223:0], nw};
      wi_nxt      = wi_r + WIdxW'(1);
      if (wi_r[2:0] == 3'd0) rc_nxt = xtime(rc_r);
      row_buf_nxt = {row_buf_r[95:0], nw};
      if (wi_r[1:0] == 2'd3) begin
        wr_en   = 1'b1;
        wr_row  = wi_r[WIdxW-1:2];
        wr_data = {row_buf_r[95:0], nw};
      end
      if (wi_r == WIdxW'(Words-1)) begin
        kx_busy_nxt = 1'b0;
        sts.kx_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) rk_mem[wr_row] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) kx_busy_r <= 1'b0;
    else        kx_busy_r <= kx_busy_nxt;
    win_r     <= win_nxt;
    wi_r      <= wi_nxt;
    rc_r      <= rc_nxt;
    row_buf_r <= row_buf_nxt;
  end

  // round unit; byte i is at st_r[127-8*i -: 8], column c is bytes 4c..4c+3
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st_r[127-8*i -: 8];
      a[i] = cmd.dec ? INV_SBOX[s[i]] : SBOX[s[i]];
    end
    for (int i = 0; i < 16; i++) begin
      // encrypt: out[4c+r] = a[4((c+r)%4)+r]; decrypt: out[4c+r] = a[4((c+3r)%4)+r]
      sr_out[127-8*i -: 8] = cmd.dec ? a[4*(((i/4)+3*(i%4))%4)+(i%4)]
                                     : a[4*(((i/4)+(i%4))%4)+(i%4)];
    end
  end

  // decrypt order: addkey then inverse mix, so mix runs on (state ^ key)
  assign dec_in = st_r ^ rk;

  always_comb begin
    logic [7:0] c0, c1, c2, c3, e0, e1, e2, e3, x0, x1, x2, x3;
    logic [7:0] y0, y1, y2, y3, z0, z1, z2, z3;
    for (int c = 0; c < 4; c++) begin
      c0 = sr_out[127-32*c -: 8];
      c1 = sr_out[119-32*c -: 8];
      c2 = sr_out[111-32*c -: 8];
      c3 = sr_out[103-32*c -: 8];
      x0 = xtime(c0); x1 = xtime(c1); x2 = xtime(c2); x3 = xtime(c3);
      m[4*c]   = x0 ^ x1 ^ c1 ^ c2 ^ c3;
      m[4*c+1] = c0 ^ x1 ^ x2 ^ c2 ^ c3;
      m[4*c+2] = c0 ^ c1 ^ x2 ^ x3 ^ c3;
      m[4*c+3] = x0 ^ c0 ^ c1 ^ c2 ^ x3;
      e0 = dec_in[127-32*c -: 8];
      e1 = dec_in[119-32*c -: 8];
      e2 = dec_in[111-32*c -: 8];
      e3 = dec_in[103-32*c -: 8];
      x0 = xtime(e0); x1 = xtime(e1); x2 = xtime(e2); x3 = xtime(e3);
      y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
      z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
      // 0e=8^4^2, 0b=8^2^1, 0d=8^4^1, 09=8^1
      mix_out[127-32*c -: 8] = (z0^y0^x0) ^ (z1^x1^e1) ^ (z2^y2^e2) ^ (z3^e3);
      mix_out[119-32*c -: 8] = (z0^e0) ^ (z1^y1^x1) ^ (z2^x2^e2) ^ (z3^y3^e3);
      mix_out[111-32*c -: 8] = (z0^y0^e0) ^ (z1^e1) ^ (z2^y2^x2) ^ (z3^x3^e3);
      mix_out[103-32*c -: 8] = (z0^x0^e0) ^ (z1^y1^e1) ^ (z2^e2) ^ (z3^y3^x3);
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) enc_mixed[127-8*i -: 8] = m[i];
  end

  // decrypt round r: st holds state after inverse shift/sub; compute
  // invsub(invshift(invmix(st ^ rk))), last round: st ^ rk
  always_comb begin
    dec_sr_in = mix_out;
    for (int i = 0; i < 16; i++) begin
      d[i] = INV_SBOX[dec_sr_in[127-8*(4*(((i/4)+3*(i%4))%4)+(i%4)) -: 8]];
      dec_round[127-8*i -: 8] = d[i];
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (cmd.load) begin
      st_nxt = {blk_hi, blk_lo};
    end
    if (cmd.round) begin
      if (!cmd.dec) st_nxt = (cmd.last ? sr_out : enc_mixed) ^ rk;
      else          st_nxt = cmd.last ? (st_r ^ rk) : dec_round;
    end else if (first_add) begin
      // first key add; decryption also applies inverse shift and sub
      st_nxt = cmd.dec ? first_dec : (st_r ^ rk);
    end
  end

  // first step of a block: encrypt adds key 0; decrypt adds key 14, then invshift, invsub
  assign first_add = !cmd.load && !cmd.round && !cmd.kx_step && !cmd.kx_start && load_pend_r;
  assign x14 = st_r ^ rk;
  always_comb begin
    for (int i = 0; i < 16; i++)
      first_dec[127-8*i -: 8] = INV_SBOX[x14[127-8*(4*(((i/4)+3*(i%4))%4)+(i%4)) -: 8]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) load_pend_r <= 1'b0;
    else if (cmd.load) load_pend_r <= 1'b1;
    else if (first_add) load_pend_r <= 1'b0;
    st_r <= st_nxt;
  end

endmodule
`default_nettype wire

// ----- sim/aes256_block_cipher_tb.sv -----
// Self-checking testbench for aes256_block_cipher: AES-256 blocks with both commands, several keys.
// Depends on aes256_pkg and the RTL top level; expected results come from its own cipher or known-answer vectors.
`default_nettype none
module aes256_block_cipher_tb
  import aes256_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 2000000;
  localparam int DrainCycles = 80;
  localparam int HoldCycles  = 600;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [127:0]       in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [127:0]       out_tdata;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]        cfg_wdata = '0;

  aes256_block_cipher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Cipher state kept by the testbench
  logic [7:0]   fwd_tab [256];
  logic [7:0]   inv_tab [256];
  logic [63:0]  key_reg [4];
  logic [31:0]  sched [60];
  logic         sched_fresh = 1'b0;
  logic [127:0] block_q [$];
  int           err_count = 0;
  int           cycle_count = 0;
  bit           hold_req = 0;
  bit           no_idle = 0;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic void build_tables();
    logic [7:0] iv, b;
    for (int x = 0; x < 256; x++) begin
      iv = '0;
      for (int y = 1; y < 256; y++)
        if (gf_mul(8'(x), 8'(y)) == 8'h01) iv = 8'(y);
      b = iv;
      fwd_tab[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                   ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) inv_tab[fwd_tab[x]] = 8'(x);
  endfunction

  function automatic logic [31:0] sub32(logic [31:0] w);
    return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
  endfunction

  function automatic void expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      sched[2*i]   = key_reg[i][63:32];
      sched[2*i+1] = key_reg[i][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      t = sched[i-1];
      if (i % 8 == 0) begin
        t = sub32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (i % 8 == 4) begin
        t = sub32(t);
      end
      sched[i] = sched[i-8] ^ t;
    end
    sched_fresh = 1'b1;
  endfunction

  function automatic void add_key(ref logic [7:0] s [16], input int rnd);
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++)
        s[4*c+j] ^= sched[4*rnd+c][31-8*j -: 8];
  endfunction

  function automatic void shift_sub(ref logic [7:0] s [16], input bit inverse);
    logic [7:0] t [16];
    t = s;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        s[4*c+r] = inverse ? inv_tab[t[4*((c + r*3) % 4)+r]] : fwd_tab[t[4*((c + r) % 4)+r]];
  endfunction

  function automatic void mix(ref logic [7:0] s [16], input bit inverse);
    logic [7:0] coef [4];
    logic [7:0] col [4];
    logic [7:0] acc;
    if (inverse) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else         coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = s[4*c+k];
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], coef[(k + 4 - r) % 4]);
        s[4*c+r] = acc;
      end
    end
  endfunction

  function automatic logic [127:0] cipher_block(logic cmd, logic [127:0] blk);
    logic [7:0]   s [16];
    logic [127:0] res;
    if (!sched_fresh) expand_schedule();
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    if (cmd == CMD_ENC) begin
      add_key(s, 0);
      for (int rnd = 1; rnd < 14; rnd++) begin
        shift_sub(s, 1'b0);
        mix(s, 1'b0);
        add_key(s, rnd);
      end
      shift_sub(s, 1'b0);
      add_key(s, 14);
    end else begin
      add_key(s, 14);
      shift_sub(s, 1'b1);
      for (int rnd = 13; rnd > 0; rnd--) begin
        add_key(s, rnd);
        mix(s, 1'b1);
        shift_sub(s, 1'b1);
      end
      add_key(s, 0);
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %s: got %h expected %h", what, got, want);
    err_count++;
  endtask

  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Send one block ({hi, lo}); the expectation is queued when the transaction completes.
  task automatic send_block(logic cmd, logic [127:0] blk, logic [127:0] want);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {blk[63:0], blk[127:64]};
    do @(posedge clk); while (!in_tready);
    block_q.push_back(want);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (block_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
    logic [63:0]        kv [4];
    logic [CfgIdxW-1:0] idx [4];
    kv = '{k0, k1, k2, k3};
    idx = '{CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= kv[i];
      key_reg[i] = kv[i];
      sched_fresh = 1'b0;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  typedef struct {
    bit           fips_key;
    logic         cmd;
    logic [127:0] blk;
    bit           typed;
    logic [127:0] want;
  } vector_t;

  localparam logic [127:0] ZeroCt = 128'hdc95c078a2408989ad48a21492842087;
  localparam logic [127:0] FipsPt = 128'h00112233445566778899aabbccddeeff;
  localparam logic [127:0] FipsCt = 128'h8ea2b7ca516745bfeafc49904b496089;

  vector_t vectors [] = '{
    '{0, CMD_ENC, '0, 1, ZeroCt},
    '{0, CMD_DEC, ZeroCt, 1, '0},
    '{0, CMD_ENC, '1, 0, '0},
    '{0, CMD_DEC, '1, 0, '0},
    '{0, CMD_DEC, '0, 0, '0},
    '{0, CMD_ENC, {64'h8000000000000000, 64'h0}, 0, '0},
    '{0, CMD_ENC, {64'h0, 64'h0000000000000001}, 0, '0},
    '{0, CMD_ENC, {16{8'h55}}, 0, '0},
    '{0, CMD_DEC, {16{8'haa}}, 0, '0},
    '{0, CMD_ENC, {64'hffffffffffffffff, 64'h0}, 0, '0},
    '{1, CMD_ENC, FipsPt, 1, FipsCt},
    '{1, CMD_DEC, FipsCt, 1, FipsPt},
    '{1, CMD_ENC, '0, 0, '0},
    '{1, CMD_DEC, '1, 0, '0},
    '{1, CMD_ENC, {64'h0, 64'hffffffffffffffff}, 0, '0}
  };

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // out_tdata carries result_hi in the low half, result_lo in the high half
  always @(posedge clk) begin : result_check
    logic [127:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (block_q.size() == 0) begin
        report_mismatch("unexpected result_hi", out_tdata[63:0], '0);
      end else begin
        want = block_q.pop_front();
        if (out_tdata[63:0] !== want[127:64])
          report_mismatch("result_hi", out_tdata[63:0], want[127:64]);
        if (out_tdata[127:64] !== want[63:0])
          report_mismatch("result_lo", out_tdata[127:64], want[63:0]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("aes256_block_cipher: mismatch");
      $finish;
    end
  end

  initial begin
    logic [127:0] blk, last_ct;
    logic         cmd;
    bit           cur_fips;
    build_tables();
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_fips = 0;
    foreach (vectors[i]) begin
      if (vectors[i].fips_key != cur_fips) begin
        drain();
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        cur_fips = vectors[i].fips_key;
      end
      blk = cipher_block(vectors[i].cmd, vectors[i].blk);
      send_block(vectors[i].cmd, vectors[i].blk, vectors[i].typed ? vectors[i].want : blk);
    end

    last_ct = '0;
    for (int p = 0; p < 10; p++) begin
      drain();
      no_idle = (p % 3 == 2);
      case (p)
        0: load_key('1, '1, '1, '1);
        1: load_key('0, '0, '0, '0);
        2: load_key({$urandom, $urandom}, key_reg[1], key_reg[2], key_reg[3]);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      if (p == 4) hold_req = 1;
      for (int n = 0; n < 190; n++) begin
        cmd = 1'($urandom);
        case ($urandom_range(0, 7))
          0: blk = '0;
          1: blk = '1;
          2, 3: blk = last_ct;
          default: blk = {$urandom, $urandom, $urandom, $urandom};
        endcase
        if (blk == last_ct && $urandom_range(0, 1) == 1) cmd = CMD_DEC;
        last_ct = cipher_block(cmd, blk);
        send_block(cmd, blk, last_ct);
        // chain ciphertext back in so decrypt sees real ciphertexts
        if (cmd == CMD_DEC) last_ct = cipher_block(CMD_ENC, {$urandom, $urandom, $urandom, $urandom});
      end
    end

    drain();
    if (err_count == 0) begin
      $display("aes256_block_cipher: match");
    end else begin
      $display("aes256_block_cipher: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/aes256_pkg.sv
rtl/aes256_ctrl.sv
rtl/aes256_dp.sv
rtl/aes256_block_cipher.sv
sim/aes256_block_cipher_tb.sv
